// ----- design/fbp_pkg.sv -----
// ============================================================================
// Flash block protect package
// Types, field widths and codes shared by the block protection unit.
// ============================================================================
`default_nettype none

package fbp_pkg;

    localparam int REGION_W = 26;
    localparam int WORD_W   = 16;

    typedef logic [1:0]          t_func;
    typedef logic [1:0]          t_status;
    typedef logic [2:0]          t_lock;
    typedef logic [1:0]          t_cfg_index;
    typedef logic [4:0]          t_cfg_data;
    typedef logic [REGION_W-1:0] t_region;
    typedef logic [WORD_W-1:0]   t_word;

    localparam t_func FUNC_QUERY = 2'd0;
    localparam t_func FUNC_SET   = 2'd1;
    localparam t_func FUNC_LOAD  = 2'd2;
    localparam t_func FUNC_NOP   = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOT_END = 2'd1;
    localparam t_status ST_BAD_SZ  = 2'd2;
    localparam t_status ST_SEC     = 2'd3;

    localparam t_lock LOCK_PRESERVE = 3'd0;
    localparam t_lock LOCK_NONE     = 3'd1;
    localparam t_lock LOCK_PIN      = 3'd2;
    localparam t_lock LOCK_REBOOT   = 3'd3;
    localparam t_lock LOCK_PERM     = 3'd4;

    localparam t_cfg_index CFG_SIZE_SHIFT = 2'd0;
    localparam t_cfg_index CFG_GRAN_SHIFT = 2'd1;
    localparam t_cfg_index CFG_BP_WIDTH   = 2'd2;

    localparam logic [4:0] SIZE_SHIFT_RST = 5'd24;
    localparam logic [4:0] GRAN_SHIFT_RST = 5'd18;
    localparam logic [2:0] BP_WIDTH_RST   = 3'd3;
    localparam logic [2:0] BP_WIDTH_FOUR  = 3'd4;

    localparam t_word PROT_MASK = 16'h407C;
    localparam t_word SRP_MASK  = 16'h0180;

    localparam int BIT_TB3  = 5;
    localparam int BIT_SEC  = 6;
    localparam int BIT_TB4  = 6;
    localparam int BIT_SRP0 = 7;
    localparam int BIT_SRP1 = 8;
    localparam int BIT_CMP  = 14;

    typedef struct packed {
        t_func   func;
        t_region region_base;
        t_region region_size;
        t_status status;
        t_word   word;
    } t_stage;

endpackage

`default_nettype wire

// ----- design/flash_block_protect_unit.sv -----
// ============================================================================
// Flash block protect unit
// Keeps a serial NOR flash status word and encodes or decodes its block
// protection bits (BP, TB, CMP, SEC, SRP) into byte regions.
// ============================================================================
// The unit accepts one item per clock and returns one result per item. An
// accepted item is registered in the first stage, and its result is then
// registered on the outputs, where it stays until it is taken. Only a stalled
// output slows the unit: it then holds one result and one more item before
// it stalls its input. The first stage applies a set or raw load to the
// status word, so the next item sees the updated word at once; the second
// stage decodes the new word into the protected region and checks coverage
// for a query. Configuration is written through a separate port that is
// always ready and must only be used while no item is in flight.
`default_nettype none

module flash_block_protect_unit #(
    parameter int MAX_SIZE_SHIFT = 25
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  fbp_pkg::t_cfg_index i_cfg_index,
    input  fbp_pkg::t_cfg_data  i_cfg_data,

    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  fbp_pkg::t_func      i_func,
    input  fbp_pkg::t_region    i_region_base,
    input  fbp_pkg::t_region    i_region_size,
    input  fbp_pkg::t_lock      i_lock_mode,
    input  fbp_pkg::t_word      i_raw_status,

    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output fbp_pkg::t_status    o_status,
    output logic                o_covered,
    output fbp_pkg::t_region    o_prot_offset,
    output fbp_pkg::t_region    o_prot_size,
    output fbp_pkg::t_word      o_status_out
);

    import fbp_pkg::*;

    localparam int AW = (MAX_SIZE_SHIFT + 2 > REGION_W + 2) ? MAX_SIZE_SHIFT + 2
                                                             : REGION_W + 2;

    function automatic logic [5:0] f_log2(input logic [AW-1:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < AW; i++) begin
            if (v[i]) begin
                r = r | 6'(i);
            end
        end
        return r;
    endfunction

    logic [4:0] r_size_shift;
    logic [4:0] r_gran_shift;
    logic [2:0] r_bp_width;
    t_word      r_status_word;
    logic       r_s1_valid;
    t_stage     r_s1;
    logic       r_out_valid;
    t_status    r_status;
    logic       r_covered;
    t_region    r_prot_offset;
    t_region    r_prot_size;
    t_word      r_status_out;

    logic          four;
    logic [5:0]    fss;
    logic [AW-1:0] fs;
    logic          s1_adv;
    logic          in_acc;

    logic [AW-1:0] s_off;
    logic [AW-1:0] s_size;
    logic          s_tb;
    logic          s_cmp;
    logic [AW-1:0] s_sz2;
    logic          s_pow2;
    logic [5:0]    s_lg;
    logic [6:0]    s_bp;
    logic          s_bad;
    t_status       n_set_status;
    t_word         s_mask;
    t_word         s_val;
    t_word         n_word;
    t_status       n_status;

    logic          d_ok;
    logic [3:0]    d_bp;
    logic          d_tb;
    logic [6:0]    d_exp;
    logic [5:0]    d_eff;
    logic [AW-1:0] d_raw;
    logic [AW-1:0] d_size;
    logic [AW-1:0] d_off;
    logic [AW-1:0] d_end;
    logic [AW-1:0] q_end;
    logic          n_covered;
    t_status       n_out_status;

    assign o_cfg_ready = 1'b1;
    assign four        = (r_bp_width == BP_WIDTH_FOUR);
    assign fss         = ({1'b0, r_size_shift} > 6'(MAX_SIZE_SHIFT)) ? 6'(MAX_SIZE_SHIFT)
                                                                     : {1'b0, r_size_shift};
    assign fs          = AW'(1) << fss;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Set: encode the region into protection bits and merge them; load: take the raw word.
    always_comb begin
        s_off  = AW'(i_region_base);
        s_size = AW'(i_region_size);
        s_tb   = (s_off == '0);
        s_cmp  = 1'b0;
        s_sz2  = s_size;
        if (s_size > (fs >> 1)) begin
            s_cmp = 1'b1;
            s_sz2 = fs - s_size;
            s_tb  = !s_tb;
        end
        s_pow2 = ((s_sz2 & (s_sz2 - AW'(1))) == '0);
        s_lg   = f_log2(s_sz2);
        s_bp   = {1'b0, s_lg} - {2'b00, r_gran_shift} + 7'd1;
        s_bad  = (s_sz2 != '0) && (!s_pow2 || (s_lg < {1'b0, r_gran_shift})
                 || (s_bp > (four ? 7'd15 : 7'd7)));
        if (s_off != '0 && (s_off + s_size) != fs) begin
            n_set_status = ST_NOT_END;
        end else if (s_size > fs || s_bad) begin
            n_set_status = ST_BAD_SZ;
        end else begin
            n_set_status = ST_OK;
        end
        if (s_sz2 == '0) begin
            s_bp = '0;
        end
        s_mask = PROT_MASK;
        s_val  = WORD_W'({s_bp[3:0], 2'b00});
        s_val[four ? BIT_TB4 : BIT_TB3] = s_tb;
        s_val[BIT_CMP] = s_cmp;
        case (i_lock_mode) inside
            LOCK_NONE, LOCK_PIN, LOCK_REBOOT, LOCK_PERM: begin
                s_mask = s_mask | SRP_MASK;
                s_val[BIT_SRP0] = (i_lock_mode == LOCK_PIN) || (i_lock_mode == LOCK_PERM);
                s_val[BIT_SRP1] = (i_lock_mode == LOCK_REBOOT) || (i_lock_mode == LOCK_PERM);
            end
            default: begin
            end
        endcase
        n_word   = r_status_word;
        n_status = ST_OK;
        if (i_func == FUNC_SET) begin
            n_status = n_set_status;
            if (n_set_status == ST_OK) begin
                n_word = (r_status_word & ~s_mask) | (s_val & s_mask);
            end
        end else if (i_func == FUNC_LOAD) begin
            n_word = i_raw_status;
        end
    end

    // Decode the word left by the item and check coverage for a query.
    always_comb begin
        d_ok  = !(!four && r_s1.word[BIT_SEC]);
        d_bp  = four ? r_s1.word[5:2] : {1'b0, r_s1.word[4:2]};
        d_tb  = four ? r_s1.word[BIT_TB4] : r_s1.word[BIT_TB3];
        d_exp = {2'b00, r_gran_shift} + {3'b000, d_bp} - 7'd1;
        d_eff = (d_exp > {1'b0, fss}) ? fss : d_exp[5:0];
        d_raw = (d_bp != '0) ? (AW'(1) << d_eff) : '0;
        if (r_s1.word[BIT_CMP]) begin
            d_size = fs - d_raw;
            d_tb   = !d_tb;
        end else begin
            d_size = d_raw;
        end
        d_off = d_tb ? '0 : fs - d_size;
        d_end = d_tb ? d_size : fs;
        if (!d_ok) begin
            d_size = '0;
            d_off  = '0;
            d_end  = '0;
        end
        q_end        = AW'(r_s1.region_base) + AW'(r_s1.region_size);
        n_covered    = 1'b0;
        n_out_status = r_s1.status;
        if (r_s1.func == FUNC_QUERY) begin
            if (!d_ok) begin
                n_out_status = ST_SEC;
            end else begin
                n_covered = (d_size != '0) && (AW'(r_s1.region_base) >= d_off)
                            && (q_end <= d_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_shift  <= SIZE_SHIFT_RST;
            r_gran_shift  <= GRAN_SHIFT_RST;
            r_bp_width    <= BP_WIDTH_RST;
            r_status_word <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SIZE_SHIFT: r_size_shift <= i_cfg_data;
                    CFG_GRAN_SHIFT: r_gran_shift <= i_cfg_data;
                    CFG_BP_WIDTH:   r_bp_width   <= i_cfg_data[2:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_status_word <= n_word;
            end
            r_s1_valid <= in_acc || (r_s1_valid && !s1_adv);
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.func        <= i_func;
            r_s1.region_base <= i_region_base;
            r_s1.region_size <= i_region_size;
            r_s1.status      <= n_status;
            r_s1.word        <= n_word;
        end
        if (s1_adv && r_s1_valid) begin
            r_status      <= n_out_status;
            r_covered     <= n_covered;
            r_prot_offset <= d_off[REGION_W-1:0];
            r_prot_size   <= d_size[REGION_W-1:0];
            r_status_out  <= r_s1.word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_covered     = r_covered;
    assign o_prot_offset = r_prot_offset;
    assign o_prot_size   = r_prot_size;
    assign o_status_out  = r_status_out;

    a_covered_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_covered |-> o_status == ST_OK)
        else $error("Covered result carries an error status.");

    a_load_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_func == FUNC_LOAD |=> r_status_word == $past(i_raw_status))
        else $error("Raw load did not replace the status word.");

    a_err_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_status != ST_OK |=> $stable(r_status_word))
        else $error("Rejected set changed the status word.");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("Input stalled while the pipeline can advance.");

endmodule

`default_nettype wire

// ----- bench/fbp_tb_pkg.sv -----
// ============================================================================
// Flash block protect testbench package
// Request and report types and a scoreboard that keeps its own copy of the
// status word and configuration, predicts each report and checks the DUT.
// ============================================================================

package fbp_tb_pkg;

    import fbp_pkg::*;

    localparam int MAX_FLASH_SHIFT = 25;
    localparam int SHOWN_MISMATCHES = 10;

    typedef logic [63:0] t_u64;

    typedef struct {
        t_func   func;
        t_region region_base;
        t_region region_size;
        t_lock   lock_mode;
        t_word   raw_status;
    } t_request;

    typedef struct {
        t_status status;
        logic    covered;
        t_region prot_offset;
        t_region prot_size;
        t_word   status_out;
    } t_report;

    class prot_scoreboard;

        t_word       word_q;
        logic [4:0]  size_shift;
        logic [4:0]  gran_shift;
        logic [2:0]  bp_width;
        t_report     awaited_reports[$];
        int          mismatches;

        function new();
            word_q     = '0;
            size_shift = SIZE_SHIFT_RST;
            gran_shift = GRAN_SHIFT_RST;
            bp_width   = BP_WIDTH_RST;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_index idx, t_cfg_data data);
            case (idx)
                CFG_SIZE_SHIFT: size_shift = data;
                CFG_GRAN_SHIFT: gran_shift = data;
                CFG_BP_WIDTH:   bp_width   = data[2:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        function t_u64 flash_bytes();
            int s;
            s = int'(size_shift);
            if (s > MAX_FLASH_SHIFT) begin
                s = MAX_FLASH_SHIFT;
            end
            return t_u64'(1) << s;
        endfunction

        // Returns 0 when the SEC bit is set in 3-bit mode.
        function bit decode_region(t_word w, output t_u64 off, output t_u64 sz);
            t_u64       fs;
            t_u64       span;
            logic [3:0] bp;
            logic       tb;
            fs = flash_bytes();
            if (bp_width == BP_WIDTH_FOUR) begin
                bp = w[5:2];
                tb = w[BIT_TB4];
            end else begin
                if (w[BIT_SEC]) begin
                    off = t_u64'(0);
                    sz  = t_u64'(0);
                    return 1'b0;
                end
                bp = {1'b0, w[4:2]};
                tb = w[BIT_TB3];
            end
            span = (bp != 0) ? ((t_u64'(1) << gran_shift) << (bp - 4'd1)) : t_u64'(0);
            if (span > fs) begin
                span = fs;
            end
            if (w[BIT_CMP]) begin
                span = fs - span;
                tb   = !tb;
            end
            off = tb ? t_u64'(0) : fs - span;
            sz  = span;
            return 1'b1;
        endfunction

        function void current_region(output t_u64 off, output t_u64 sz);
            void'(decode_region(word_q, off, sz));
        endfunction

        function t_status encode_region(t_u64 off, t_u64 sz, t_lock mode);
            t_u64       fs;
            t_u64       gran;
            t_u64       bp_max;
            t_u64       bp;
            t_u64       span;
            logic       tb;
            logic       cmp;
            logic [2:0] srp;
            t_word      mask;
            t_word      val;
            fs     = flash_bytes();
            gran   = t_u64'(1) << gran_shift;
            bp_max = (bp_width == BP_WIDTH_FOUR) ? t_u64'(15) : t_u64'(7);
            bp     = t_u64'(0);
            cmp    = 1'b0;
            span   = sz;
            if (off != 0 && off + span != fs) begin
                return ST_NOT_END;
            end
            if (span > fs) begin
                return ST_BAD_SZ;
            end
            tb = (off == 0);
            if (span > fs / 2) begin
                cmp  = 1'b1;
                span = fs - span;
                tb   = !tb;
            end
            if (span != 0) begin
                if ((span & (span - 1)) != 0 || span < gran) begin
                    return ST_BAD_SZ;
                end
                bp = t_u64'($clog2(span) - int'(gran_shift) + 1);
                if (bp > bp_max) begin
                    return ST_BAD_SZ;
                end
            end
            mask = PROT_MASK;
            val  = t_word'(bp << 2);
            if (bp_width == BP_WIDTH_FOUR) begin
                val[BIT_TB4] = tb;
            end else begin
                val[BIT_TB3] = tb;
            end
            val[BIT_CMP] = cmp;
            if (mode >= LOCK_NONE && mode <= LOCK_PERM) begin
                srp            = mode - LOCK_NONE;
                mask           = mask | SRP_MASK;
                val[BIT_SRP0]  = srp[0];
                val[BIT_SRP1]  = srp[1];
            end
            word_q = (word_q & ~mask) | (val & mask);
            return ST_OK;
        endfunction

        function void note_request(t_request req);
            t_report rep;
            t_u64    po;
            t_u64    ps;
            bit      ok;
            rep.status  = ST_OK;
            rep.covered = 1'b0;
            case (req.func)
                FUNC_SET:  rep.status = encode_region(t_u64'(req.region_base),
                                                      t_u64'(req.region_size),
                                                      req.lock_mode);
                FUNC_LOAD: word_q = req.raw_status;
                default: ;
            endcase
            ok = decode_region(word_q, po, ps);
            if (req.func == FUNC_QUERY) begin
                if (!ok) begin
                    rep.status = ST_SEC;
                end else if (ps != 0 && t_u64'(req.region_base) >= po &&
                             t_u64'(req.region_base) + t_u64'(req.region_size) <= po + ps) begin
                    rep.covered = 1'b1;
                end
            end
            rep.prot_offset = po[REGION_W-1:0];
            rep.prot_size   = ps[REGION_W-1:0];
            rep.status_out  = word_q;
            awaited_reports.push_back(rep);
        endfunction

        function void check_report(t_report got);
            t_report want;
            if (awaited_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES) begin
                    $display("unexpected report: status %0d covered %0d offset %h size %h word %h",
                             got.status, got.covered, got.prot_offset, got.prot_size,
                             got.status_out);
                end
                return;
            end
            want = awaited_reports.pop_front();
            if (want.status !== got.status || want.covered !== got.covered ||
                want.prot_offset !== got.prot_offset || want.prot_size !== got.prot_size ||
                want.status_out !== got.status_out) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES) begin
                    $display("report mismatch: expected status %0d covered %0d offset %h size %h word %h",
                             want.status, want.covered, want.prot_offset, want.prot_size,
                             want.status_out);
                    $display("                 actual   status %0d covered %0d offset %h size %h word %h",
                             got.status, got.covered, got.prot_offset, got.prot_size,
                             got.status_out);
                end
            end
        endfunction

    endclass

endpackage

// ----- bench/testbench.sv -----
// ============================================================================
// Flash block protect unit testbench
// Drives query, set, raw-load and no-op items through the unit under several
// flash geometries and BP widths, with random sender gaps and receiver stalls,
// and checks every report against the scoreboard's prediction.
// ============================================================================

module testbench;

    import fbp_pkg::*;
    import fbp_tb_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int      WATCHDOG_LIMIT = 3000;
    localparam int      HOLD_CYCLES    = 60;
    localparam int      PHASE_ITEMS    = 90;
    localparam int      DRAIN_CYCLES   = 8;
    localparam t_lock   LOCK_ODD_LO    = 3'd5;
    localparam t_lock   LOCK_ODD_HI    = 3'd7;
    localparam t_region FLASH_RST      = 26'h1000000;
    localparam t_region GRAN_RST       = 26'h0040000;
    localparam t_region REGION_ALL1    = 26'h3FFFFFF;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    t_cfg_index cfg_index;
    t_cfg_data  cfg_data;
    logic       in_valid;
    logic       in_stall;
    t_func      in_func;
    t_region    in_offset;
    t_region    in_size;
    t_lock      in_lock;
    t_word      in_raw;
    logic       out_valid;
    logic       out_stall;
    t_status    out_status;
    logic       out_covered;
    t_region    out_prot_offset;
    t_region    out_prot_size;
    t_word      out_word;

    prot_scoreboard sb;
    t_idle_mode     idle_mode;
    int             hold_requests;
    int             holds_served;
    int             quiet_cycles;

    flash_block_protect_unit #(
        .MAX_SIZE_SHIFT(MAX_FLASH_SHIFT)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (in_func),
        .i_region_base  (in_offset),
        .i_region_size  (in_size),
        .i_lock_mode    (in_lock),
        .i_raw_status   (in_raw),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (out_status),
        .o_covered      (out_covered),
        .o_prot_offset  (out_prot_offset),
        .o_prot_size    (out_prot_size),
        .o_status_out   (out_word)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) begin
        t_request req;
        t_report  rep;
        logic     progress;
        progress = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                req.func          = in_func;
                req.region_base   = in_offset;
                req.region_size   = in_size;
                req.lock_mode     = in_lock;
                req.raw_status    = in_raw;
                sb.note_request(req);
                progress = 1'b1;
            end
            if (out_valid && !out_stall) begin
                rep.status      = out_status;
                rep.covered     = out_covered;
                rep.prot_offset = out_prot_offset;
                rep.prot_size   = out_prot_size;
                rep.status_out  = out_word;
                sb.check_report(rep);
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                progress = 1'b1;
            end
        end
        quiet_cycles = progress ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("flash_block_protect_unit test failed");
            $finish;
        end
    end

    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (idle_mode == IDLE_RECV) begin
                out_stall = ($urandom_range(99) < 77);
            end else if (idle_mode == IDLE_BOTH) begin
                out_stall = ($urandom_range(99) < 29);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    function automatic int draw_gap();
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 29 : 0;
        while ($urandom_range(99) < pct) begin
            gap++;
        end
        return gap;
    endfunction

    task automatic drive_request(t_request req);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_func   = req.func;
        in_offset = req.region_base;
        in_size   = req.region_size;
        in_lock   = req.lock_mode;
        in_raw    = req.raw_status;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send(t_func f, t_region off, t_region sz, t_lock lk, t_word raw);
        t_request req;
        req.func          = f;
        req.region_base   = off;
        req.region_size   = sz;
        req.lock_mode     = lk;
        req.raw_status    = raw;
        drive_request(req);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_index idx, t_cfg_data data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(t_cfg_data size_sh, t_cfg_data gran_sh, t_cfg_data bpw);
        wait_drained();
        write_reg(CFG_SIZE_SHIFT, size_sh);
        write_reg(CFG_GRAN_SHIFT, gran_sh);
        write_reg(CFG_BP_WIDTH, bpw);
    endtask

    function automatic t_request make_request();
        t_request req;
        t_u64     fs;
        t_u64     po;
        t_u64     ps;
        t_u64     sz;
        t_u64     off;
        int       k;
        int       pick;
        req.region_base   = t_region'($urandom);
        req.region_size   = t_region'($urandom);
        req.lock_mode     = t_lock'($urandom_range(7));
        req.raw_status    = t_word'($urandom);
        fs   = sb.flash_bytes();
        k    = $urandom_range($clog2(fs), int'(sb.gran_shift));
        pick = $urandom_range(99);
        if (pick < 40) begin
            req.func = FUNC_SET;
            if ($urandom_range(9) < 8) begin
                sz = ($urandom_range(7) == 0) ? t_u64'(0) : t_u64'(1) << k;
                if ($urandom_range(1)) begin
                    sz = fs - sz;
                end
                req.region_size   = t_region'(sz);
                req.region_base   = $urandom_range(1) ? t_region'(0) : t_region'(fs - sz);
            end else begin
                case ($urandom_range(3))
                    0: ;
                    1: begin
                        req.region_base   = '0;
                        req.region_size   = t_region'($urandom_range(32'(2 * fs)));
                    end
                    2: begin
                        req.region_base   = '0;
                        req.region_size   = t_region'((t_u64'(1) << k) + $urandom_range(2) - 1);
                    end
                    default: begin
                        sz = t_u64'($urandom_range(32'(fs)));
                        req.region_size   = t_region'(sz);
                        req.region_base   = t_region'(fs - sz);
                    end
                endcase
            end
        end else if (pick < 75) begin
            req.func = FUNC_QUERY;
            if ($urandom_range(3) != 0) begin
                sb.current_region(po, ps);
                if (ps == 0) begin
                    po = t_u64'(0);
                    ps = fs;
                end
                off = po + t_u64'($urandom_range(32'(ps)));
                sz  = t_u64'($urandom_range(32'(po + ps - off)));
                if ($urandom_range(3) == 0) begin
                    sz = sz + t_u64'(1 + $urandom_range(3));
                end
                req.region_base   = t_region'(off);
                req.region_size   = t_region'(sz);
            end
        end else if (pick < 92) begin
            req.func = FUNC_LOAD;
            if ($urandom_range(1)) begin
                req.raw_status[BIT_SEC] = 1'b0;
            end
        end else begin
            req.func = FUNC_NOP;
        end
        return req;
    endfunction

    task automatic run_phase(t_idle_mode mode, int count);
        idle_mode = mode;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_drained();
            end
            drive_request(make_request());
        end
    endtask

    initial begin
        sb            = new();
        idle_mode     = IDLE_NONE;
        hold_requests = 0;
        holds_served  = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SIZE_SHIFT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_func       = FUNC_NOP;
        in_offset     = '0;
        in_size       = '0;
        in_lock       = LOCK_PRESERVE;
        in_raw        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(FUNC_QUERY, '0, GRAN_RST, LOCK_PRESERVE, '0);
        send(FUNC_SET, '0, GRAN_RST, LOCK_NONE, '0);
        send(FUNC_QUERY, '0, GRAN_RST, LOCK_PRESERVE, '0);
        send(FUNC_QUERY, '0, GRAN_RST + 26'd1, LOCK_PRESERVE, '0);
        send(FUNC_SET, FLASH_RST - 26'h400000, 26'h400000, LOCK_PIN, '0);
        send(FUNC_QUERY, FLASH_RST - 26'h400000, 26'h400000, LOCK_PRESERVE, '0);
        send(FUNC_SET, '0, FLASH_RST, LOCK_REBOOT, '0);
        send(FUNC_QUERY, '0, FLASH_RST, LOCK_PRESERVE, '0);
        send(FUNC_SET, '0, '0, LOCK_PERM, '0);
        send(FUNC_QUERY, '0, '0, LOCK_PRESERVE, '0);
        send(FUNC_SET, GRAN_RST, GRAN_RST, LOCK_NONE, '0);
        send(FUNC_SET, '0, t_region'(3 * GRAN_RST), LOCK_NONE, '0);
        send(FUNC_SET, '0, 26'h10000, LOCK_NONE, '0);
        send(FUNC_SET, '0, t_region'(2 * FLASH_RST), LOCK_NONE, '0);
        send(FUNC_SET, '0, FLASH_RST - GRAN_RST, LOCK_ODD_LO, '0);
        send(FUNC_QUERY, GRAN_RST, t_region'(FLASH_RST - 2 * GRAN_RST), LOCK_PRESERVE, '0);
        send(FUNC_LOAD, '0, '0, LOCK_PRESERVE, 16'h0040);
        send(FUNC_QUERY, '0, GRAN_RST, LOCK_PRESERVE, '0);
        send(FUNC_LOAD, '0, '0, LOCK_PRESERVE, 16'hFFFF);
        send(FUNC_QUERY, REGION_ALL1, REGION_ALL1, LOCK_ODD_HI, '0);
        send(FUNC_NOP, REGION_ALL1, REGION_ALL1, LOCK_ODD_HI, 16'hFFFF);
        send(FUNC_LOAD, '0, '0, LOCK_PRESERVE, 16'h0000);
        send(FUNC_SET, FLASH_RST - GRAN_RST, GRAN_RST, LOCK_PRESERVE, '0);

        wait_drained();
        hold_requests++;
        run_phase(IDLE_NONE, PHASE_ITEMS);

        set_geometry(5'd20, 5'd16, 5'd3);
        run_phase(IDLE_SEND, PHASE_ITEMS);

        set_geometry(5'd25, 5'd16, 5'd3);
        send(FUNC_SET, '0, 26'h1000000, LOCK_NONE, '0);
        run_phase(IDLE_RECV, PHASE_ITEMS);

        set_geometry(5'd25, 5'd18, 5'd4);
        run_phase(IDLE_BOTH, PHASE_ITEMS);

        set_geometry(5'd20, 5'd18, 5'd4);
        run_phase(IDLE_RECV, PHASE_ITEMS);

        set_geometry(5'd31, 5'd17, 5'd4);
        send(FUNC_SET, '0, 26'h2000000, LOCK_NONE, '0);
        send(FUNC_QUERY, '0, 26'h2000000, LOCK_PRESERVE, '0);
        run_phase(IDLE_SEND, PHASE_ITEMS);

        set_geometry(5'd22, 5'd17, 5'd3);
        run_phase(IDLE_BOTH, PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("flash_block_protect_unit test passed");
        end else begin
            $display("flash_block_protect_unit test failed");
        end
        $finish;
    end

endmodule
